// ===== src/urlpd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, character codes and hex digit decode for the URL percent decoder.
package urlpd_pkg;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] HexBad    = 8'hFF;
  localparam int unsigned QDepth   = 3;

  typedef enum logic [1:0] {
    PH_TEXT  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } result_t;

  function automatic logic [7:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = HexBad;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h41 + 8'd10;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h61 + 8'd10;
    return v;
  endfunction

  function automatic logic [7:0] plain(input logic [7:0] c);
    return (c == ChPlus) ? ChSpace : c;
  endfunction

endpackage

// ===== src/url_percent_decoder.sv =====
`timescale 1ns / 1ps
// URL percent decoder: one encoded byte per transfer, decoded bytes out.
//
// Takes one byte per clock while the queue has room. A '+' becomes a space,
// '%' and two hex digits become one byte, everything else passes through. A
// '%' and the digit after it produce no output; a string that ends one byte
// after a '%' produces two outputs (the literal '%', then that byte). Decoding
// is combinational logic from the input transfer into a three-entry output
// queue; input is taken while at most one decoded byte waits, so the sustained
// rate is one byte per cycle while the output is ready, with an input stall
// after a double result. m_axis_tuser marks the last output of one input
// transfer, m_axis_tlast the final decoded byte of the string.
module url_percent_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] run_last
  output logic       m_axis_tlast    // string_end
);
  import urlpd_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] first_q, first_d;
  result_t    q_q [QDepth];
  result_t    q_d [QDepth];
  logic [1:0] cnt_q, cnt_d;

  logic       in_fire, out_fire;
  logic [1:0] res_n;
  result_t    res0, res1;
  logic [7:0] hi, lo;
  logic [1:0] base;

  assign s_axis_tready = (cnt_q <= 2'd1);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = q_q[0].out_byte;
  assign m_axis_tuser  = q_q[0].run_last;
  assign m_axis_tlast  = q_q[0].string_end;

  assign hi = hex_val(first_q);
  assign lo = hex_val(s_axis_tdata);

  always_comb begin
    phase_d = phase_q;
    first_d = first_q;
    res_n   = 2'd0;
    res0    = '{out_byte: plain(s_axis_tdata), run_last: 1'b1, string_end: s_axis_tlast};
    res1    = '{out_byte: plain(s_axis_tdata), run_last: 1'b1, string_end: 1'b1};
    if (in_fire) begin
      unique case (phase_q)
        PH_PCT: begin
          if (s_axis_tlast) begin
            res0    = '{out_byte: ChPercent, run_last: 1'b0, string_end: 1'b0};
            res_n   = 2'd2;
            phase_d = PH_TEXT;
          end else begin
            first_d = s_axis_tdata;
            phase_d = PH_DIGIT;
          end
        end
        PH_DIGIT: begin
          res0.out_byte = (lo == HexBad) ? HexBad : {hi[3:0], lo[3:0]};
          res_n         = 2'd1;
          phase_d       = PH_TEXT;
        end
        default: begin
          phase_d = PH_TEXT;
          if (s_axis_tdata == ChPercent && !s_axis_tlast) begin
            phase_d = PH_PCT;
          end else begin
            res_n = 2'd1;
          end
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      q_d[i] = q_q[i];
    end
    if (out_fire) begin
      for (int i = 0; i < QDepth - 1; i++) begin
        q_d[i] = q_q[i + 1];
      end
    end
    base = cnt_q - {1'b0, out_fire};
    if (res_n != 2'd0) q_d[base] = res0;
    if (res_n == 2'd2) q_d[base + 2'd1] = res1;
    cnt_d = base + res_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TEXT;
      first_q <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      first_q <= first_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !out_fire |-> cnt_q <= 2'd1)
    else $error("output queue overflow");

  a_digit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == PH_DIGIT |=> phase_q == PH_TEXT && cnt_q != 2'd0)
    else $error("escape not completed");

  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("string end without run end");

  a_pending_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == PH_PCT && !s_axis_tlast && !out_fire |=> $stable(cnt_q))
    else $error("output during pending escape");

endmodule
